>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled during reset.
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("assertion failed");

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
   else $error("implication failed");

`endif

>>> sv/pcd_pkg.sv
`timescale 1ns / 1ps

package pcd_pkg;

   localparam int ADDR_W  = 32;
   localparam int SET_LSB = 5;
   localparam int TAG_LSB = 12;
   localparam int TAG_W   = ADDR_W - TAG_LSB;
   localparam int WAYS    = 8;
   localparam int WAY_W   = 3;
   localparam int TREE_W  = 7;
   localparam int META_W  = WAYS + TREE_W;
   localparam int ROW_W   = WAYS * TAG_W;

   // Tree update masks: keep / set bits on the path of the used way.
   localparam logic [TREE_W-1:0] SET_W0  = 7'b1101000;
   localparam logic [TREE_W-1:0] KEEP_W1 = 7'b0010111;
   localparam logic [TREE_W-1:0] SET_W1  = 7'b1100000;
   localparam logic [TREE_W-1:0] KEEP_W2 = 7'b0011011;
   localparam logic [TREE_W-1:0] SET_W2  = 7'b1000100;
   localparam logic [TREE_W-1:0] KEEP_W4 = 7'b0101101;
   localparam logic [TREE_W-1:0] SET_W4  = 7'b0010010;
   localparam logic [TREE_W-1:0] SET_W5  = 7'b0010000;
   localparam logic [TREE_W-1:0] KEEP_W6 = 7'b0101110;
   localparam logic [TREE_W-1:0] SET_W6  = 7'b0000001;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INDEX,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic [WAYS-1:0]   valid;
      logic [TREE_W-1:0] tree;
   } meta_type;

   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             write_back;
   } lookup_type;

   // Point the tree bits away from the way just used.
   function automatic logic [TREE_W-1:0] tree_touch(input logic [TREE_W-1:0] t,
                                                    input logic [WAY_W-1:0] w);
      logic [TREE_W-1:0] r;
      case (w)
         3'd0: r = t | SET_W0;
         3'd1: r = (t & KEEP_W1) | SET_W1;
         3'd2: r = (t & KEEP_W2) | SET_W2;
         3'd3: r = (t & KEEP_W2) | SET_W1 & SET_W2;
         3'd4: r = (t & KEEP_W4) | SET_W4;
         3'd5: r = (t & KEEP_W4) | SET_W5;
         3'd6: r = (t & KEEP_W6) | SET_W6;
         default: r = t & KEEP_W6;
      endcase
      return r;
   endfunction

   // Walk the tree to the pseudo-LRU way.
   function automatic logic [WAY_W-1:0] tree_victim(input logic [TREE_W-1:0] t);
      logic [WAY_W-1:0] v;
      if (!t[6]) begin
         if (!t[5]) v = t[3] ? 3'd1 : 3'd0;
         else       v = t[2] ? 3'd3 : 3'd2;
      end else begin
         if (!t[4]) v = t[1] ? 3'd5 : 3'd4;
         else       v = t[0] ? 3'd7 : 3'd6;
      end
      return v;
   endfunction

endpackage

>>> sv/pcd_ram.sv
`timescale 1ns / 1ps

module pcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/pcd_index.sv
`timescale 1ns / 1ps

// Set index = (address >> 5) mod NUM_SETS.
// Power of two: a bit slice, ready in the start cycle.
// Otherwise: reciprocal multiply for the quotient, then a multiply-subtract for
// the remainder; the address and then the quotient are registered before the index is valid.
module pcd_index #(
   parameter int NUM_SETS = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pcd_pkg::ADDR_W-1:0]  address,
   output logic                        idx_valid,
   output logic [$clog2(NUM_SETS)-1:0] idx
);

   localparam int SET_W = $clog2(NUM_SETS);

   if ((NUM_SETS & (NUM_SETS - 1)) == 0) begin : g_pow2
      logic unused_ok;
      assign unused_ok = clock ^ reset;
      assign idx_valid = start;
      assign idx       = address[pcd_pkg::SET_LSB +: SET_W];
   end else begin : g_reduce
      // q = floor(x / NUM_SETS) is exact for every x below 2^STEPS with
      // RECIP = ceil(2^SHIFT / NUM_SETS); the remainder fits in SET_W bits,
      // so x - q * NUM_SETS is taken in the low SET_W bits only.
      localparam int STEPS  = pcd_pkg::ADDR_W - pcd_pkg::SET_LSB;
      localparam int SHIFT  = STEPS + SET_W;
      localparam int M_W    = STEPS + 1;
      localparam int PROD_W = STEPS + M_W;
      localparam logic [M_W-1:0] RECIP =
         M_W'(((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));

      logic              mul_ff;      // x captured, quotient being formed
      logic              sub_ff;      // quotient captured, index on the output
      logic [STEPS-1:0]  x_ff;
      logic [SET_W-1:0]  q_ff;
      logic [PROD_W-1:0] prod;
      logic [SET_W-1:0]  q_in;

      assign prod = PROD_W'(x_ff) * PROD_W'(RECIP);
      assign q_in = SET_W'(prod >> SHIFT);

      always_ff @(posedge clock) begin
         if (reset) begin
            mul_ff <= 1'b0;
            sub_ff <= 1'b0;
         end else begin
            mul_ff <= start;
            sub_ff <= mul_ff;
         end
         if (start) begin
            x_ff <= address[pcd_pkg::ADDR_W-1:pcd_pkg::SET_LSB];
         end
         if (mul_ff) begin
            q_ff <= q_in;
         end
      end

      assign idx_valid = sub_ff;
      assign idx       = x_ff[SET_W-1:0] - q_ff * SET_W'(NUM_SETS);
   end

endmodule

>>> sv/pcd_lookup.sv
`timescale 1ns / 1ps

// Tag compare, way selection and the read-modify-write values for one set.
module pcd_lookup (
   input  logic [pcd_pkg::TAG_W-1:0] tag,
   input  pcd_pkg::meta_type         meta,
   input  logic [pcd_pkg::ROW_W-1:0] row,
   output pcd_pkg::lookup_type       res,
   output pcd_pkg::meta_type         meta_new,
   output logic [pcd_pkg::ROW_W-1:0] row_new
);

   logic [pcd_pkg::WAYS-1:0]  match;
   logic [pcd_pkg::WAY_W-1:0] hit_way;
   logic [pcd_pkg::WAY_W-1:0] free_way;
   logic                      all_valid;

   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int i = 0; i < pcd_pkg::WAYS; i++) begin
         match[i] = meta.valid[i] && (row[i*pcd_pkg::TAG_W +: pcd_pkg::TAG_W] == tag);
         if (match[i]) hit_way = pcd_pkg::WAY_W'(i);   // highest match wins
      end
      for (int i = pcd_pkg::WAYS - 1; i >= 0; i--) begin
         if (!meta.valid[i]) free_way = pcd_pkg::WAY_W'(i);  // lowest free wins
      end
      all_valid      = &meta.valid;
      res.hit        = |match;
      res.write_back = !res.hit && all_valid;
      if (res.hit)         res.way = hit_way;
      else if (!all_valid) res.way = free_way;
      else                 res.way = pcd_pkg::tree_victim(meta.tree);

      meta_new.valid = meta.valid | (pcd_pkg::WAYS'(1) << res.way);
      meta_new.tree  = pcd_pkg::tree_touch(meta.tree, res.way);
      for (int i = 0; i < pcd_pkg::WAYS; i++) begin
         row_new[i*pcd_pkg::TAG_W +: pcd_pkg::TAG_W] =
            (res.way == pcd_pkg::WAY_W'(i)) ? tag : row[i*pcd_pkg::TAG_W +: pcd_pkg::TAG_W];
      end
   end

endmodule

>>> sv/eight_way_plru_cache_directory_core.sv
`timescale 1ns / 1ps
// Result: registered in the output register after the metadata and tag RAM read of the set;
//   a reciprocal-multiply set-index reduction runs first unless NUM_SETS is a power of two.
// Beats: one in flight; a new request is taken only in idle, after the read-then-write of
//   the set in the metadata and tag RAMs (registered read), which waits for output room.
// Reset: synchronous; a pass over the NUM_SETS rows clears valid/tree bits, no beat taken.
module eight_way_plru_cache_directory_core #(
   parameter int NUM_SETS = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [pcd_pkg::ADDR_W-1:0] req_address,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic [pcd_pkg::WAY_W-1:0]  rsp_way,
   output logic                       rsp_write_back
);

   localparam int SET_W = $clog2(NUM_SETS);

   pcd_pkg::state_type state_ff, state_in;
   logic [SET_W-1:0]   clr_ff, clr_in;     // clearing-pass row pointer
   logic [SET_W-1:0]   set_ff, set_in;     // set of the beat in flight
   logic [pcd_pkg::TAG_W-1:0] tag_ff, tag_in;

   // Output register: decouples the lookup from a stalled consumer.
   logic                      rsp_valid_ff, rsp_valid_in;
   pcd_pkg::lookup_type       rsp_ff, rsp_in;

   logic                      req_beat;
   logic                      idx_valid;
   logic [SET_W-1:0]          idx;
   logic                      update;
   logic                      clearing;

   pcd_pkg::meta_type         meta_rd, meta_new, meta_wr;
   logic [pcd_pkg::ROW_W-1:0] row_rd, row_new;
   pcd_pkg::lookup_type       res;

   assign req_beat = req_valid && req_ready;

   pcd_index #(.NUM_SETS(NUM_SETS)) u_index (
      .clock     (clock),
      .reset     (reset),
      .start     (req_beat),
      .address   (req_address),
      .idx_valid (idx_valid),
      .idx       (idx)
   );

   // Valid bits + tree bits, one row per set.
   assign meta_wr = clearing ? pcd_pkg::meta_type'('0) : meta_new;

   pcd_ram #(.WIDTH(pcd_pkg::META_W), .DEPTH(NUM_SETS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (clearing || update),
      .wr_addr (clearing ? clr_ff : set_ff),
      .wr_data (meta_wr),
      .rd_en   (idx_valid),
      .rd_addr (idx),
      .rd_data (meta_rd)
   );

   // Tags of all eight ways, one row per set; never cleared (guarded by valid bits).
   pcd_ram #(.WIDTH(pcd_pkg::ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (update),
      .wr_addr (set_ff),
      .wr_data (row_new),
      .rd_en   (idx_valid),
      .rd_addr (idx),
      .rd_data (row_rd)
   );

   pcd_lookup u_lookup (
      .tag      (tag_ff),
      .meta     (meta_rd),
      .row      (row_rd),
      .res      (res),
      .meta_new (meta_new),
      .row_new  (row_new)
   );

   // Next state and control. One beat in flight at a time, so the write-back
   // of a set always lands before the next read of any set: no forwarding needed.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      req_ready = 1'b0;
      update    = 1'b0;
      clearing  = 1'b0;
      case (state_ff)
         pcd_pkg::ST_CLEAR: begin
            clearing = 1'b1;
            clr_in   = clr_ff + SET_W'(1);
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = pcd_pkg::ST_IDLE;
            end
         end
         pcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = idx_valid ? pcd_pkg::ST_LOOKUP : pcd_pkg::ST_INDEX;
            end
         end
         pcd_pkg::ST_INDEX: begin
            if (idx_valid) begin
               state_in = pcd_pkg::ST_LOOKUP;
            end
         end
         pcd_pkg::ST_LOOKUP: begin
            // RAM read data holds until the output register has room.
            if (!rsp_valid_ff || rsp_ready) begin
               update   = 1'b1;
               state_in = pcd_pkg::ST_IDLE;
            end
         end
         default: state_in = pcd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      set_in       = idx_valid ? idx : set_ff;
      tag_in       = req_beat ? req_address[pcd_pkg::ADDR_W-1:pcd_pkg::TAG_LSB] : tag_ff;
      rsp_in       = update ? res : rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcd_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      set_ff <= set_in;
      tag_ff <= tag_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_ff.hit;
   assign rsp_way        = rsp_ff.way;
   assign rsp_write_back = rsp_ff.write_back;

endmodule

>>> sv/pcd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [pcd_pkg::ADDR_W-1:0] req_address,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_hit,
   input logic [pcd_pkg::WAY_W-1:0]  rsp_way,
   input logic                       rsp_write_back
);

   logic unused_addr;
   assign unused_addr = ^req_address;

   // A stalled result beat holds.
   `ASSERT_AT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_hit, rsp_way, rsp_write_back})))

   // Write-back only on a miss.
   `ASSERT_IMPLY(a_wb_miss, clock, reset, rsp_valid && rsp_write_back, !rsp_hit)

   // One beat in flight: request side closes right after a beat.
   `ASSERT_AT(a_one_inflight, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // A new result only appears while a lookup was in progress.
   `ASSERT_AT(a_rsp_from_lookup, clock, reset, $rose(rsp_valid) |-> $past(!req_ready))

endmodule

bind eight_way_plru_cache_directory_core pcd_checker u_pcd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_address    (req_address),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hit        (rsp_hit),
   .rsp_way        (rsp_way),
   .rsp_write_back (rsp_write_back)
);
